// File: src/lru_cache_with_pending_fills_defines.svh
// Assertion macros used by the LRU cache slot table.
`ifndef LRU_CACHE_WITH_PENDING_FILLS_DEFINES_SVH
`define LRU_CACHE_WITH_PENDING_FILLS_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define LCPF_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define LCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LCPF_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define LCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/lcpf_pkg.sv
// Shared types and constants for the LRU cache with pending fills.
package lcpf_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;

    localparam int CAP_W   = 5;
    localparam int KEY_W   = 64;
    localparam int PAY_W   = 32;
    localparam int EVT_W   = 3;
    localparam int CNTO_W  = 5;
    localparam int STAT_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

    typedef enum logic [EVT_W-1:0] {
        EV_HIT      = 3'd0,
        EV_MISS     = 3'd1,
        EV_WAIT     = 3'd2,
        EV_FILLED   = 3'd3,
        EV_FAILED   = 3'd4,
        EV_EMPTY    = 3'd5,
        EV_UNC_MISS = 3'd6,
        EV_UNC_FILL = 3'd7
    } t_event;

    // Table update chosen for the item in the input register.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC,
        OP_TOUCH,
        OP_FREE,
        OP_FILL
    } t_op;

    // Lookup status from the slot table.
    typedef struct packed {
        logic hit;
        logic hit_rdy;
        logic free_ok;
        logic evict_any;
    } t_look;

    // Single-step statistics increments.
    typedef struct packed {
        logic hit;
        logic miss;
        logic pend;
        logic err;
    } t_stat_inc;

endpackage

// File: src/lcpf_table.sv
// Slot table: tag compare cells, recency ranks, free-slot pick and eviction.
`include "lru_cache_with_pending_fills_defines.svh"

module lcpf_table #(
    parameter int ENTRIES  = lcpf_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lcpf_pkg::KEY_BITS_DEF,
    parameter int CNT_W    = $clog2(ENTRIES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [KEY_BITS-1:0]        i_key,
    input  logic [lcpf_pkg::CAP_W-1:0] i_cap,
    input  lcpf_pkg::t_op              i_op,
    input  logic [lcpf_pkg::PAY_W-1:0] i_payload,
    output lcpf_pkg::t_look            o_look,
    output logic [lcpf_pkg::PAY_W-1:0] o_hit_payload,
    output logic [KEY_BITS-1:0]        o_evict_key,
    output logic [CNT_W-1:0]           o_evict_num,
    output logic [CNT_W-1:0]           o_count
);
    import lcpf_pkg::*;

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [ENTRIES-1:0]  r_ready, n_ready;
    logic [AGE_W-1:0]    r_age [ENTRIES];
    logic [AGE_W-1:0]    n_age [ENTRIES];
    logic [KEY_BITS-1:0] r_key [ENTRIES];
    logic [PAY_W-1:0]    r_pay [ENTRIES];
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rdy_cnt, n_rdy_cnt;

    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  free_oh;
    logic [ENTRIES-1:0]  ev_mask;
    logic [ENTRIES-1:0]  first_vic;
    logic [AGE_W-1:0]    hit_age;
    logic [CMP_W-1:0]    rdy_after;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    ev_num_w;

    // Per-slot compare and eviction decision
    always_comb begin
        logic found;
        logic [CMP_W-1:0] nage;
        found         = 1'b0;
        hit_age       = '0;
        o_hit_payload = '0;
        o_evict_key   = '0;
        cap_ext       = CMP_W'(i_cap);
        rdy_after     = CMP_W'(r_rdy_cnt) + CMP_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]   = r_valid[i] && (r_key[i] == i_key);
            free_oh[i] = !r_valid[i] && !found;
            found      = found || !r_valid[i];
            // ranks of the other ready slots move up by one on a fill
            nage         = CMP_W'(r_age[i]) + CMP_W'(1);
            ev_mask[i]   = r_ready[i] && !match[i] && (nage >= cap_ext);
            first_vic[i] = ev_mask[i] && (nage == CMP_W'(r_rdy_cnt));
            if (match[i]) begin
                hit_age       = hit_age | r_age[i];
                o_hit_payload = o_hit_payload | r_pay[i];
            end
            if (first_vic[i]) begin
                o_evict_key = o_evict_key | r_key[i];
            end
        end
        ev_num_w = (rdy_after > cap_ext) ? (rdy_after - cap_ext) : '0;
        o_evict_num      = CNT_W'(ev_num_w);
        o_look.hit       = |match;
        o_look.hit_rdy   = |(match & r_ready);
        o_look.free_ok   = found;
        o_look.evict_any = (rdy_after > cap_ext);
    end

    always_comb begin
        n_valid   = r_valid;
        n_ready   = r_ready;
        n_count   = r_count;
        n_rdy_cnt = r_rdy_cnt;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        case (i_op)
            OP_ALLOC: begin
                n_valid = r_valid | free_oh;
                n_ready = r_ready & ~free_oh;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_oh[i]) begin
                        n_age[i] = '0;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
            OP_TOUCH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match[i]) begin
                        n_age[i] = '0;
                    end else if (r_ready[i] && (r_age[i] < hit_age)) begin
                        n_age[i] = r_age[i] + AGE_W'(1);
                    end
                end
            end
            OP_FREE: begin
                n_valid = r_valid & ~match;
                n_ready = r_ready & ~match;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match[i]) begin
                        n_age[i] = '0;
                    end
                end
                n_count = r_count - CNT_W'(1);
            end
            OP_FILL: begin
                n_valid = r_valid & ~ev_mask;
                n_ready = (r_ready & ~ev_mask) | match;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match[i] || ev_mask[i]) begin
                        n_age[i] = '0;
                    end else if (r_ready[i]) begin
                        n_age[i] = r_age[i] + AGE_W'(1);
                    end
                end
                n_count   = r_count - o_evict_num;
                n_rdy_cnt = r_rdy_cnt + CNT_W'(1) - o_evict_num;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ready   <= '0;
            r_count   <= '0;
            r_rdy_cnt <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid   <= n_valid;
            r_ready   <= n_ready;
            r_count   <= n_count;
            r_rdy_cnt <= n_rdy_cnt;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if ((i_op == OP_ALLOC) && free_oh[i]) begin
                r_key[i] <= i_key;
            end
            if ((i_op == OP_FILL) && match[i]) begin
                r_pay[i] <= i_payload;
            end
        end
    end

    assign o_count = r_count;

    `LCPF_ASSERT_ALWAYS(a_key_unique, i_clk, i_rst_n, $onehot0(match), "duplicate key in table")
    `LCPF_ASSERT_ALWAYS(a_ready_valid, i_clk, i_rst_n, (r_ready & ~r_valid) == '0, "ready slot not valid")
    `LCPF_ASSERT_ALWAYS(a_count, i_clk, i_rst_n, $countones(r_valid) == int'(r_count), "entry count drift")
    `LCPF_ASSERT_ALWAYS(a_rdy_count, i_clk, i_rst_n, $countones(r_ready) == int'(r_rdy_cnt), "ready count drift")
endmodule

// File: src/lcpf_stats.sv
// Saturating statistics counters.
module lcpf_stats #(
    parameter int EVN_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcpf_pkg::t_stat_inc         i_inc,
    input  logic [EVN_W-1:0]            i_evict_num,
    output logic [lcpf_pkg::STAT_W-1:0] o_hit_count,
    output logic [lcpf_pkg::STAT_W-1:0] o_miss_count,
    output logic [lcpf_pkg::STAT_W-1:0] o_wait_count,
    output logic [lcpf_pkg::STAT_W-1:0] o_eviction_count,
    output logic [lcpf_pkg::STAT_W-1:0] o_error_count
);
    import lcpf_pkg::*;

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] v,
                                                  input logic [STAT_W-1:0] n);
        logic [STAT_W:0] sum;
        sum = {1'b0, v} + {1'b0, n};
        return sum[STAT_W] ? '1 : sum[STAT_W-1:0];
    endfunction

    logic [STAT_W-1:0] r_hit, r_miss, r_pend, r_evict, r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= '0;
            r_miss  <= '0;
            r_pend  <= '0;
            r_evict <= '0;
            r_err   <= '0;
        end else begin
            r_hit   <= sat_add(r_hit,   STAT_W'(i_inc.hit));
            r_miss  <= sat_add(r_miss,  STAT_W'(i_inc.miss));
            r_pend  <= sat_add(r_pend,  STAT_W'(i_inc.pend));
            r_evict <= sat_add(r_evict, STAT_W'(i_evict_num));
            r_err   <= sat_add(r_err,   STAT_W'(i_inc.err));
        end
    end

    assign o_hit_count      = r_hit;
    assign o_miss_count     = r_miss;
    assign o_wait_count     = r_pend;
    assign o_eviction_count = r_evict;
    assign o_error_count    = r_err;
endmodule

// File: src/lru_cache_with_pending_fills.sv
// Fully associative LRU cache with pending fills: top level.
// An item is taken on every clock (busy never rises). The accept edge loads
// the input register; the slot table then decodes the item into the result
// register, and o_strobe is high while that register holds the result.
// The decode is a parallel tag compare and recency update over all
// slots. Results cannot be stalled; o_strobe lasts one cycle per item,
// and the entry count and statistics outputs are current while it is high.
module lru_cache_with_pending_fills #(
    parameter int ENTRIES  = lcpf_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lcpf_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [lcpf_pkg::KEY_W-1:0]   i_key,
    input  logic                         i_key_empty,
    input  logic                         i_fill_ok,
    input  logic [lcpf_pkg::PAY_W-1:0]   i_fill_payload,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lcpf_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                         o_strobe,
    output logic [lcpf_pkg::EVT_W-1:0]   o_event_res,
    output logic [lcpf_pkg::PAY_W-1:0]   o_payload_out,
    output logic                         o_evicted,
    output logic [lcpf_pkg::KEY_W-1:0]   o_evicted_key,
    output logic [lcpf_pkg::CNTO_W-1:0]  o_entry_count,
    output logic [lcpf_pkg::STAT_W-1:0]  o_hit_count,
    output logic [lcpf_pkg::STAT_W-1:0]  o_miss_count,
    output logic [lcpf_pkg::STAT_W-1:0]  o_wait_count,
    output logic [lcpf_pkg::STAT_W-1:0]  o_eviction_count,
    output logic [lcpf_pkg::STAT_W-1:0]  o_error_count
);
    import lcpf_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    // input register
    logic                r_vld;
    logic                r_action;
    logic [KEY_BITS-1:0] r_key;
    logic                r_empty;
    logic                r_ok;
    logic [PAY_W-1:0]    r_pay;
    logic [CAP_W-1:0]    r_cap;

    // result register
    logic                r_strobe;
    t_event              r_event, n_event;
    logic [PAY_W-1:0]    r_pout, n_pout;
    logic                r_evd, n_evd;
    logic [KEY_BITS-1:0] r_evkey, n_evkey;

    t_op                 op;
    t_look               look;
    t_stat_inc           inc;
    logic [PAY_W-1:0]    hit_payload;
    logic [KEY_BITS-1:0] evict_key;
    logic [CNT_W-1:0]    evict_num;
    logic [CNT_W-1:0]    evict_inc;
    logic [CNT_W-1:0]    count;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cap <= CAP_RST;
        end else begin
            r_vld <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_action <= i_action;
            r_key    <= KEY_BITS'(i_key);
            r_empty  <= i_key_empty;
            r_ok     <= i_fill_ok;
            r_pay    <= i_fill_payload;
        end
    end

    lcpf_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .CNT_W    (CNT_W)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (r_key),
        .i_cap         (r_cap),
        .i_op          (op),
        .i_payload     (r_pay),
        .o_look        (look),
        .o_hit_payload (hit_payload),
        .o_evict_key   (evict_key),
        .o_evict_num   (evict_num),
        .o_count       (count)
    );

    // Decode the item in the input register against the table
    always_comb begin
        op        = OP_NONE;
        inc       = '0;
        evict_inc = '0;
        n_event   = EV_HIT;
        n_pout    = '0;
        n_evd     = 1'b0;
        n_evkey   = '0;
        if (r_vld) begin
            if (!r_action) begin
                if (r_empty) begin
                    n_event = EV_EMPTY;
                end else if (r_cap == '0) begin
                    n_event  = EV_UNC_MISS;
                    inc.miss = 1'b1;
                end else if (look.hit) begin
                    if (look.hit_rdy) begin
                        n_event = EV_HIT;
                        n_pout  = hit_payload;
                        op      = OP_TOUCH;
                        inc.hit = 1'b1;
                    end else begin
                        n_event  = EV_WAIT;
                        inc.pend = 1'b1;
                    end
                end else begin
                    inc.miss = 1'b1;
                    if (look.free_ok) begin
                        n_event = EV_MISS;
                        op      = OP_ALLOC;
                    end else begin
                        n_event = EV_UNC_MISS;
                    end
                end
            end else begin
                // fill with nothing pending for the key passes through
                if ((r_cap == '0) || !look.hit || look.hit_rdy) begin
                    n_event = EV_UNC_FILL;
                    if (r_ok) begin
                        n_pout = r_pay;
                    end else begin
                        inc.err = 1'b1;
                    end
                end else if (!r_ok) begin
                    n_event = EV_FAILED;
                    op      = OP_FREE;
                    inc.err = 1'b1;
                end else begin
                    n_event   = EV_FILLED;
                    n_pout    = r_pay;
                    op        = OP_FILL;
                    n_evd     = look.evict_any;
                    n_evkey   = look.evict_any ? evict_key : '0;
                    evict_inc = evict_num;
                end
            end
        end
    end

    lcpf_stats #(
        .EVN_W (CNT_W)
    ) u_stats (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_inc            (inc),
        .i_evict_num      (evict_inc),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_wait_count     (o_wait_count),
        .o_eviction_count (o_eviction_count),
        .o_error_count    (o_error_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event <= n_event;
        r_pout  <= n_pout;
        r_evd   <= n_evd;
        r_evkey <= n_evkey;
    end

    assign o_strobe      = r_strobe;
    assign o_event_res   = r_event;
    assign o_payload_out = r_pout;
    assign o_evicted     = r_evd;
    assign o_evicted_key = KEY_W'(r_evkey);
    assign o_entry_count = CNTO_W'(count);
endmodule
